/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the path command front end.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define VPC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define VPC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define VPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/vpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_pkg
// Types and codes shared by the path command front end.
// ----------------------------------------------------------------------------
package vpc_pkg;

  localparam int XY_BITS = 32;

  // command codes
  localparam logic [2:0] MODE_MOVE   = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_QUAD   = 3'd2;
  localparam logic [2:0] MODE_SQUAD  = 3'd3;
  localparam logic [2:0] MODE_CUBIC  = 3'd4;
  localparam logic [2:0] MODE_SCUBIC = 3'd5;
  localparam logic [2:0] MODE_CLOSE  = 3'd6;

  // segment kinds
  localparam logic [1:0] SEG_MOVE  = 2'd0;
  localparam logic [1:0] SEG_LINE  = 2'd1;
  localparam logic [1:0] SEG_QUAD  = 2'd2;
  localparam logic [1:0] SEG_CUBIC = 2'd3;

  // null mask bit positions
  localparam int NB_END_X   = 0;
  localparam int NB_END_Y   = 1;
  localparam int NB_CTRL1_X = 2;
  localparam int NB_CTRL1_Y = 3;
  localparam int NB_CTRL2_X = 4;
  localparam int NB_CTRL2_Y = 5;

  typedef struct packed {
    logic [2:0]                 mode;
    logic                       relative;
    logic [5:0]                 null_mask;
    logic signed [XY_BITS-1:0]  end_x;
    logic signed [XY_BITS-1:0]  end_y;
    logic signed [XY_BITS-1:0]  ctrl1_x;
    logic signed [XY_BITS-1:0]  ctrl1_y;
    logic signed [XY_BITS-1:0]  ctrl2_x;
    logic signed [XY_BITS-1:0]  ctrl2_y;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [XY_BITS-1:0]  end_x;
    logic signed [XY_BITS-1:0]  end_y;
    logic signed [XY_BITS-1:0]  c1_x;
    logic signed [XY_BITS-1:0]  c1_y;
    logic signed [XY_BITS-1:0]  c2_x;
    logic signed [XY_BITS-1:0]  c2_y;
    logic signed [XY_BITS-1:0]  box_left;
    logic signed [XY_BITS-1:0]  box_top;
    logic signed [XY_BITS-1:0]  box_right;
    logic signed [XY_BITS-1:0]  box_bottom;
    logic                       last;
  } seg_t;

endpackage

/* src/vpc_path_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_path_state
// Path state registers and the one-pass command resolver.
// ----------------------------------------------------------------------------
module vpc_path_state #(
  parameter int COORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  vpc_pkg::cmd_t  cmd,
  output logic [1:0]     seg_n,
  output vpc_pkg::seg_t  seg_a,
  output vpc_pkg::seg_t  seg_b
);

  localparam int CW = COORD_BITS;
  localparam int XB = vpc_pkg::XY_BITS;
  // wide enough for cur + raw and for 2*cur - ref without overflow
  localparam int WW = ((CW > XB) ? CW : XB) + 2;
  localparam logic signed [WW-1:0] HI_W = {{(WW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [WW-1:0] LO_W = ~HI_W;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    crd_t left;
    crd_t top;
    crd_t right;
    crd_t bottom;
  } box_t;

  function automatic wide_t ext_c(input crd_t v);
    return {{(WW-CW){v[CW-1]}}, v};
  endfunction

  function automatic wide_t ext_i(input logic signed [XB-1:0] v);
    return {{(WW-XB){v[XB-1]}}, v};
  endfunction

  function automatic crd_t sat_w(input wide_t v);
    crd_t r;
    if (v > HI_W) begin
      r = HI_W[CW-1:0];
    end else if (v < LO_W) begin
      r = LO_W[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic crd_t resolve(input logic signed [XB-1:0] raw, input logic is_null,
                                   input logic rel, input crd_t base);
    crd_t r;
    if (is_null) begin
      r = base;
    end else if (rel) begin
      r = sat_w(ext_c(base) + ext_i(raw));
    end else begin
      r = sat_w(ext_i(raw));
    end
    return r;
  endfunction

  function automatic crd_t reflect(input crd_t c, input crd_t rf);
    return sat_w(ext_c(c) + ext_c(c) - ext_c(rf));
  endfunction

  function automatic logic signed [XB-1:0] to_port(input crd_t v);
    wide_t w;
    w = ext_c(v);
    return w[XB-1:0];
  endfunction

  function automatic crd_t min2(input crd_t a, input crd_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic crd_t max2(input crd_t a, input crd_t b);
    return (a > b) ? a : b;
  endfunction

  crd_t cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic cur_valid_r, cur_valid_nxt;
  crd_t start_x_r, start_y_r, start_x_nxt, start_y_nxt;
  logic start_valid_r, start_valid_nxt;
  crd_t qref_x_r, qref_y_r, qref_x_nxt, qref_y_nxt;
  crd_t cref_x_r, cref_y_r, cref_x_nxt, cref_y_nxt;
  box_t box_r, box_nxt;

  logic       is_draw, is_quad, is_cubic, is_smooth, is_close, is_move;
  logic [1:0] kind;
  logic       move_ins, close_go, act, cv_eff;
  crd_t       base_x, base_y;
  crd_t       c1_x, c1_y, c2_x, c2_y, e_x, e_y;
  crd_t       c1b_x, c1b_y, c2b_x, c2b_y;
  box_t       box0;
  crd_t       zero_c;

  assign zero_c = '0;

  // command decode
  always_comb begin
    is_draw   = 1'b0;
    is_quad   = 1'b0;
    is_cubic  = 1'b0;
    is_smooth = 1'b0;
    is_close  = 1'b0;
    is_move   = 1'b0;
    kind      = vpc_pkg::SEG_MOVE;
    unique case (cmd.mode) inside
      vpc_pkg::MODE_MOVE: begin
        is_move = 1'b1;
      end
      vpc_pkg::MODE_LINE: begin
        is_draw = 1'b1;
        kind    = vpc_pkg::SEG_LINE;
      end
      vpc_pkg::MODE_QUAD, vpc_pkg::MODE_SQUAD: begin
        is_draw   = 1'b1;
        is_quad   = 1'b1;
        is_smooth = (cmd.mode == vpc_pkg::MODE_SQUAD);
        kind      = vpc_pkg::SEG_QUAD;
      end
      vpc_pkg::MODE_CUBIC, vpc_pkg::MODE_SCUBIC: begin
        is_draw   = 1'b1;
        is_cubic  = 1'b1;
        is_smooth = (cmd.mode == vpc_pkg::MODE_SCUBIC);
        kind      = vpc_pkg::SEG_CUBIC;
      end
      vpc_pkg::MODE_CLOSE: begin
        is_close = 1'b1;
        kind     = vpc_pkg::SEG_LINE;
      end
      default: begin
      end
    endcase
  end

  // point resolution and box update
  always_comb begin
    move_ins = is_draw && !start_valid_r;
    close_go = is_close && start_valid_r &&
               ((cur_x_r != start_x_r) || (cur_y_r != start_y_r));
    act      = is_move || is_draw || close_go;
    cv_eff   = cur_valid_r || move_ins;

    // inserted move puts the current point at the origin
    base_x = move_ins ? zero_c : cur_x_r;
    base_y = move_ins ? zero_c : cur_y_r;

    if (move_ins) begin
      if (cur_valid_r) begin
        box0.left   = min2(box_r.left, zero_c);
        box0.top    = min2(box_r.top, zero_c);
        box0.right  = max2(box_r.right, zero_c);
        box0.bottom = max2(box_r.bottom, zero_c);
      end else begin
        box0 = '0;
      end
    end else begin
      box0 = box_r;
    end

    // smooth reflection uses the current point before any inserted move
    if (is_smooth) begin
      c1_x = reflect(cur_x_r, is_quad ? qref_x_r : cref_x_r);
      c1_y = reflect(cur_y_r, is_quad ? qref_y_r : cref_y_r);
    end else begin
      c1_x = resolve(cmd.ctrl1_x, cmd.null_mask[vpc_pkg::NB_CTRL1_X], cmd.relative, base_x);
      c1_y = resolve(cmd.ctrl1_y, cmd.null_mask[vpc_pkg::NB_CTRL1_Y], cmd.relative, base_y);
    end
    c2_x = resolve(cmd.ctrl2_x, cmd.null_mask[vpc_pkg::NB_CTRL2_X], cmd.relative, base_x);
    c2_y = resolve(cmd.ctrl2_y, cmd.null_mask[vpc_pkg::NB_CTRL2_Y], cmd.relative, base_y);

    if (is_close) begin
      e_x = start_x_r;
      e_y = start_y_r;
    end else begin
      e_x = resolve(cmd.end_x, cmd.null_mask[vpc_pkg::NB_END_X], cmd.relative, base_x);
      e_y = resolve(cmd.end_y, cmd.null_mask[vpc_pkg::NB_END_Y], cmd.relative, base_y);
    end

    // unused points stand in as the end point, which leaves the box alone
    c1b_x = (is_quad || is_cubic) ? c1_x : e_x;
    c1b_y = (is_quad || is_cubic) ? c1_y : e_y;
    c2b_x = is_cubic ? c2_x : e_x;
    c2b_y = is_cubic ? c2_y : e_y;

    box_nxt.left   = min2(min2(cv_eff ? box0.left : e_x, c1b_x), min2(c2b_x, e_x));
    box_nxt.top    = min2(min2(cv_eff ? box0.top : e_y, c1b_y), min2(c2b_y, e_y));
    box_nxt.right  = max2(max2(cv_eff ? box0.right : e_x, c1b_x), max2(c2b_x, e_x));
    box_nxt.bottom = max2(max2(cv_eff ? box0.bottom : e_y, c1b_y), max2(c2b_y, e_y));
  end

  // next state
  always_comb begin
    cur_x_nxt       = e_x;
    cur_y_nxt       = e_y;
    cur_valid_nxt   = 1'b1;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    start_valid_nxt = start_valid_r;
    qref_x_nxt      = qref_x_r;
    qref_y_nxt      = qref_y_r;
    cref_x_nxt      = cref_x_r;
    cref_y_nxt      = cref_y_r;

    if (is_move) begin
      start_x_nxt     = e_x;
      start_y_nxt     = e_y;
      start_valid_nxt = 1'b1;
    end else if (move_ins) begin
      start_x_nxt     = zero_c;
      start_y_nxt     = zero_c;
      start_valid_nxt = 1'b1;
      qref_x_nxt      = zero_c;
      qref_y_nxt      = zero_c;
      cref_x_nxt      = zero_c;
      cref_y_nxt      = zero_c;
    end else if (is_close) begin
      start_valid_nxt = 1'b0;
    end

    if (is_quad) begin
      qref_x_nxt = c1_x;
      qref_y_nxt = c1_y;
    end else if (is_cubic) begin
      cref_x_nxt = c2_x;
      cref_y_nxt = c2_y;
    end else begin
      // move, line and close
      qref_x_nxt = e_x;
      qref_y_nxt = e_y;
      cref_x_nxt = e_x;
      cref_y_nxt = e_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      cur_valid_r   <= 1'b0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      start_valid_r <= 1'b0;
      qref_x_r      <= '0;
      qref_y_r      <= '0;
      cref_x_r      <= '0;
      cref_y_r      <= '0;
      box_r         <= '0;
    end else if (take && act) begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      cur_valid_r   <= cur_valid_nxt;
      start_x_r     <= start_x_nxt;
      start_y_r     <= start_y_nxt;
      start_valid_r <= start_valid_nxt;
      qref_x_r      <= qref_x_nxt;
      qref_y_r      <= qref_y_nxt;
      cref_x_r      <= cref_x_nxt;
      cref_y_r      <= cref_y_nxt;
      box_r         <= box_nxt;
    end
  end

  // result records
  vpc_pkg::seg_t rec_move, rec_main;

  always_comb begin
    rec_move            = '0;
    rec_move.kind       = vpc_pkg::SEG_MOVE;
    rec_move.box_left   = to_port(box0.left);
    rec_move.box_top    = to_port(box0.top);
    rec_move.box_right  = to_port(box0.right);
    rec_move.box_bottom = to_port(box0.bottom);

    rec_main            = '0;
    rec_main.kind       = kind;
    rec_main.end_x      = to_port(e_x);
    rec_main.end_y      = to_port(e_y);
    if (is_quad || is_cubic) begin
      rec_main.c1_x = to_port(c1_x);
      rec_main.c1_y = to_port(c1_y);
    end
    if (is_cubic) begin
      rec_main.c2_x = to_port(c2_x);
      rec_main.c2_y = to_port(c2_y);
    end
    rec_main.box_left   = to_port(box_nxt.left);
    rec_main.box_top    = to_port(box_nxt.top);
    rec_main.box_right  = to_port(box_nxt.right);
    rec_main.box_bottom = to_port(box_nxt.bottom);
    rec_main.last       = 1'b1;

    seg_a = move_ins ? rec_move : rec_main;
    seg_b = rec_main;
    if (!act) begin
      seg_n = 2'd0;
    end else if (move_ins) begin
      seg_n = 2'd2;
    end else begin
      seg_n = 2'd1;
    end
  end

endmodule

/* src/vector_path_command_front_end_core.sv */
`timescale 1ns / 1ps
// A result is registered into the result queue and presented on out_* in the cycle after its command is accepted.
// Throughput: one command per cycle while out_stall is low; a drawing command with no open subpath
//   yields a move plus its segment and holds off the next command until the move is popped.
// The cycle is set by the resolve add, saturate and box min/max on the path state.
// Reset: synchronous, active low; clears the path state and empties the result queue.
// ----------------------------------------------------------------------------
// vector_path_command_front_end_core
// Turns path commands into absolute segments with a running bounding box.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_path_command_front_end_core #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,

  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic               in_relative,
  input  logic [5:0]         in_null_mask,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_ctrl1_x,
  input  logic signed [31:0] in_ctrl1_y,
  input  logic signed [31:0] in_ctrl2_x,
  input  logic signed [31:0] in_ctrl2_y,

  // segment channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_seg_kind,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic signed [31:0] out_c1_x,
  output logic signed [31:0] out_c1_y,
  output logic signed [31:0] out_c2_x,
  output logic signed [31:0] out_c2_y,
  output logic signed [31:0] out_box_left,
  output logic signed [31:0] out_box_top,
  output logic signed [31:0] out_box_right,
  output logic signed [31:0] out_box_bottom,
  output logic               out_last
);

  // --------------------------------------------------------------------------
  // Result queue: two entries. q0 drives the output; q1 holds the segment that
  // follows an inserted move. A command transaction is taken only when the
  // queue will be empty after this cycle's pop, so a new command always writes
  // from the head and never has to merge with older results.
  // --------------------------------------------------------------------------
  vpc_pkg::seg_t q0_r, q0_nxt;
  vpc_pkg::seg_t q1_r, q1_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  logic          pop;
  logic          take;
  logic [1:0]    seg_n;
  vpc_pkg::seg_t seg_a, seg_b;
  vpc_pkg::cmd_t cmd;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  // free slot after the pop is all that counts; command payload is not looked at
  assign in_stall  = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && out_stall);
  assign take      = in_valid && !in_stall;

  always_comb begin
    cmd.mode      = in_mode;
    cmd.relative  = in_relative;
    cmd.null_mask = in_null_mask;
    cmd.end_x     = in_end_x;
    cmd.end_y     = in_end_y;
    cmd.ctrl1_x   = in_ctrl1_x;
    cmd.ctrl1_y   = in_ctrl1_y;
    cmd.ctrl2_x   = in_ctrl2_x;
    cmd.ctrl2_y   = in_ctrl2_y;
  end

  // path state and single-pass resolve
  vpc_path_state #(
    .COORD_BITS (COORD_BITS)
  ) u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .cmd   (cmd),
    .seg_n (seg_n),
    .seg_a (seg_a),
    .seg_b (seg_b)
  );

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (take) begin
      // queue drains to empty this cycle; load from the head
      q0_nxt  = seg_a;
      q1_nxt  = seg_b;
      cnt_nxt = seg_n;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_seg_kind   = q0_r.kind;
  assign out_end_x      = q0_r.end_x;
  assign out_end_y      = q0_r.end_y;
  assign out_c1_x       = q0_r.c1_x;
  assign out_c1_y       = q0_r.c1_y;
  assign out_c2_x       = q0_r.c2_x;
  assign out_c2_y       = q0_r.c2_y;
  assign out_box_left   = q0_r.box_left;
  assign out_box_top    = q0_r.box_top;
  assign out_box_right  = q0_r.box_right;
  assign out_box_bottom = q0_r.box_bottom;
  assign out_last       = q0_r.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VPC_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "result queue count out of range")
  `VPC_ASSERT_NEXT(a_pair_held, clk, rst_n, take && (seg_n == 2'd2), out_valid && in_stall, "two-segment command not queued as a pair")
  `VPC_ASSERT_IMPL(a_move_followed, clk, rst_n, out_valid && !out_last, cnt_r == 2'd2, "inserted move without its segment behind it")
  `VPC_ASSERT_IMPL(a_empty_takes, clk, rst_n, !out_valid, !in_stall, "empty queue refuses a command")

endmodule
